// ----- sv/hse_pkg.sv -----
// Package for the HMAC/SHA-256 engine: round constants, initial hash values,
// controller command and status structs. No dependencies.
package hse_pkg;

    localparam logic [31:0] IPAD = 32'h36363636;
    localparam logic [31:0] OPAD = 32'h5c5c5c5c;
    localparam logic [31:0] PAD_WORD = 32'h80000000;

    localparam logic [2:0] SRC_DATA  = 3'd0;
    localparam logic [2:0] SRC_IPAD  = 3'd1;
    localparam logic [2:0] SRC_OPAD  = 3'd2;
    localparam logic [2:0] SRC_ZERO  = 3'd3;
    localparam logic [2:0] SRC_LENHI = 3'd4;
    localparam logic [2:0] SRC_LENLO = 3'd5;
    localparam logic [2:0] SRC_INNER = 3'd6;
    localparam logic [2:0] SRC_PAD   = 3'd7;

    typedef logic [31:0] t_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       push;       // write one word into the block buffer
        logic [2:0] src;        // source of the pushed word
        logic [3:0] key_idx;    // key or inner digest index for padded words
        logic       len_add;    // add data byte count to bit length
        logic       len_set512; // set bit length to 512
        logic       len_add256; // add 256 to bit length
        logic       save_inner; // copy chain value into inner digest
        logic       restart;    // reset chain value, length and fill
        logic [2:0] out_idx;    // digest word selected for output
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       busy;       // compression running
        logic [3:0] fill;       // block buffer fill
        logic       len_zero;   // bit length is zero
    } t_sts;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[i];
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] h [8];
        h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
              32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
        return h[i];
    endfunction

endpackage

// ----- sv/hse_if.sv -----
// Valid/ready stream interfaces for request and digest channels.
// Depends on nothing.
interface hse_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
    modport source (output valid, func, data_word, byte_count, last_word, input ready);
    modport sink (input valid, func, data_word, byte_count, last_word, output ready);
endinterface

interface hse_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_result;
    modport source (output valid, digest_word, word_index, last_result, input ready);
    modport sink (input valid, digest_word, word_index, last_result, output ready);
endinterface

// ----- sv/hmac_sha256_engine.sv -----
// HMAC/SHA-256 engine top level: APB mode register, sequencer and datapath.
// The word that fills a 16-word block starts a compression (64 rounds and a
// feed-forward add); no request word is taken while it runs.
// After a last word: padding, up to two blocks, an outer pass in HMAC mode,
// then eight digest words. Synchronous active-low reset restores the initial
// hash, clears key store, length and mode.
module hmac_sha256_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    hse_in_if.sink      in_ch,
    hse_out_if.source   out_ch
);
    import hse_pkg::*;

    localparam logic [1:0] REG_HMAC_MODE = 2'd0;

    logic        r_mode;
    t_cmd        cmd;
    t_sts        sts;
    logic        key_we, key_clear;
    logic [3:0]  key_idx_w;
    logic [31:0] data, digest;
    logic [2:0]  count;

    // Mode register.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (psel && penable && pwrite && paddr == REG_HMAC_MODE) begin
            r_mode <= pwdata[0];
        end
    end
    assign prdata = (paddr == REG_HMAC_MODE) ? {31'd0, r_mode} : 32'd0;

    hse_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_hmac_mode(r_mode),
        .in_ch(in_ch), .out_ch(out_ch), .i_sts(sts), .i_digest(digest),
        .o_cmd(cmd), .o_key_we(key_we), .o_key_clear(key_clear),
        .o_key_idx_w(key_idx_w), .o_data(data), .o_count(count)
    );

    hse_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_key_we(key_we),
        .i_key_clear(key_clear), .i_key_idx_w(key_idx_w), .i_data(data),
        .i_count(count), .o_sts(sts), .o_digest(digest)
    );

    // No request is taken while a digest is being delivered.
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(out_ch.valid && in_ch.ready)) else $error("input taken during output");
    // The last digest word carries index seven.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.last_result |-> out_ch.word_index == 3'd7)
        else $error("last flag on wrong index");
    // No word is pushed while compression runs.
    a_no_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.busy |-> !cmd.push) else $error("push while busy");

endmodule

// ----- sv/hse_datapath.sv -----
// SHA-256 datapath: block buffer, key store, chain value, round unit.
// Depends on hse_pkg.
module hse_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hse_pkg::t_cmd       i_cmd,
    input  logic                i_key_we,
    input  logic                i_key_clear,
    input  logic [3:0]          i_key_idx_w,
    input  logic [31:0]         i_data,
    input  logic [2:0]          i_count,
    output hse_pkg::t_sts       o_sts,
    output logic [31:0]         o_digest
);
    import hse_pkg::*;

    logic [31:0] r_buf [16];
    logic [31:0] r_key [16];
    logic [31:0] r_inner [8];
    logic [31:0] r_chain [8];
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [63:0] r_len;
    logic [3:0]  r_fill;
    logic        r_busy;
    logic [5:0]  r_round;
    logic        r_fin;
    logic [31:0] push_word;
    logic [31:0] t1, t2, s0, s1, w_new;

    // Word selection for a buffer write.
    always_comb begin
        case (i_cmd.src)
            SRC_DATA:  push_word = i_data;
            SRC_IPAD:  push_word = r_key[i_cmd.key_idx] ^ IPAD;
            SRC_OPAD:  push_word = r_key[i_cmd.key_idx] ^ OPAD;
            SRC_LENHI: push_word = r_len[63:32];
            SRC_LENLO: push_word = r_len[31:0];
            SRC_INNER: push_word = r_inner[i_cmd.key_idx[2:0]];
            SRC_PAD:   push_word = PAD_WORD;
            default:   push_word = '0;
        endcase
    end

    // Round logic and message schedule.
    always_comb begin
        s0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
        s1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
           ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        t1 = r_h + ({r_e[5:0], r_e[31:6]} ^ {r_e[10:0], r_e[31:11]} ^ {r_e[24:0], r_e[31:25]})
           + ((r_e & r_f) ^ (~r_e & r_g)) + round_k(r_round) + r_w[0];
        t2 = ({r_a[1:0], r_a[31:2]} ^ {r_a[12:0], r_a[31:13]} ^ {r_a[21:0], r_a[31:22]})
           + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));
    end

    // Key store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_key[i] <= '0;
        end else if (i_key_clear) begin
            for (int i = 0; i < 16; i++) r_key[i] <= '0;
            if (i_key_we) r_key[i_key_idx_w] <= i_data;
        end else if (i_key_we) begin
            r_key[i_key_idx_w] <= i_data;
        end
    end

    // Buffer, length, compression control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_len <= '0;
            r_busy <= 1'b0;
            r_fin <= 1'b0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) r_chain[i] <= init_hash(3'(i));
        end else begin
            if (i_cmd.len_add) r_len <= r_len + 64'({i_count, 3'b000});
            if (i_cmd.len_set512) r_len <= 64'd512;
            if (i_cmd.len_add256) r_len <= r_len + 64'd256;
            if (i_cmd.save_inner) begin
                for (int i = 0; i < 8; i++) r_inner[i] <= r_chain[i];
            end
            if (i_cmd.push) begin
                r_buf[r_fill] <= push_word;
                r_fill <= r_fill + 4'd1;
                if (r_fill == 4'd15) begin
                    r_busy <= 1'b1;
                    r_round <= '0;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_buf[i];
                    r_w[15] <= push_word;
                    r_a <= r_chain[0]; r_b <= r_chain[1]; r_c <= r_chain[2];
                    r_d <= r_chain[3]; r_e <= r_chain[4]; r_f <= r_chain[5];
                    r_g <= r_chain[6]; r_h <= r_chain[7];
                end
            end
            if (r_busy) begin
                r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
                r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w_new;
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin <= 1'b1;
                end
            end
            // Feed-forward add in the cycle after the last round.
            if (r_fin) begin
                r_fin <= 1'b0;
                r_chain[0] <= r_chain[0] + r_a; r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c; r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e; r_chain[5] <= r_chain[5] + r_f;
                r_chain[6] <= r_chain[6] + r_g; r_chain[7] <= r_chain[7] + r_h;
            end
            if (i_cmd.restart) begin
                r_len <= '0;
                r_fill <= '0;
                for (int i = 0; i < 8; i++) r_chain[i] <= init_hash(3'(i));
            end
        end
    end

    assign o_sts.busy = r_busy | r_fin;
    assign o_sts.fill = r_fill;
    assign o_sts.len_zero = (r_len == 64'd0);
    assign o_digest = r_chain[i_cmd.out_idx];

endmodule

// ----- sv/hse_ctrl.sv -----
// Sequencer for the HMAC/SHA-256 engine: request intake, padding, outer pass,
// digest output. Depends on hse_pkg and the stream interfaces.
module hse_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_hmac_mode,
    hse_in_if.sink          in_ch,
    hse_out_if.source       out_ch,
    input  hse_pkg::t_sts   i_sts,
    input  logic [31:0]     i_digest,
    output hse_pkg::t_cmd   o_cmd,
    output logic            o_key_we,
    output logic            o_key_clear,
    output logic [3:0]      o_key_idx_w,
    output logic [31:0]     o_data,
    output logic [2:0]      o_count
);
    import hse_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_IPAD   = 4'd1;
    localparam logic [3:0] ST_DATA   = 4'd2;
    localparam logic [3:0] ST_PAD    = 4'd3;
    localparam logic [3:0] ST_ZERO   = 4'd4;
    localparam logic [3:0] ST_LENHI  = 4'd5;
    localparam logic [3:0] ST_LENLO  = 4'd6;
    localparam logic [3:0] ST_WAIT   = 4'd7;
    localparam logic [3:0] ST_OPAD   = 4'd8;
    localparam logic [3:0] ST_INNER  = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    logic [3:0]  r_state, n_state;
    logic [3:0]  r_cnt, n_cnt;
    logic [4:0]  r_kfill, n_kfill;
    logic        r_outer, n_outer;
    logic        r_hmac, n_hmac;
    logic        r_need_pad, n_need_pad;
    logic [31:0] r_word, n_word;
    logic [2:0]  r_count, n_count;
    logic        r_last, n_last;
    logic [2:0]  eff_count;
    logic [31:0] mask;
    logic        in_fire;

    assign in_fire = in_ch.valid & in_ch.ready;
    assign eff_count = (!in_ch.last_word || in_ch.byte_count > 3'd4) ? 3'd4
                                                                   : in_ch.byte_count;
    always_comb begin
        case (eff_count)
            3'd0:    mask = 32'h00000000;
            3'd1:    mask = 32'hff000000;
            3'd2:    mask = 32'hffff0000;
            3'd3:    mask = 32'hffffff00;
            default: mask = 32'hffffffff;
        endcase
    end

    assign in_ch.ready = (r_state == ST_IDLE) && !i_sts.busy;

    // Key loads go straight into the key store.
    assign o_key_clear = in_fire && in_ch.func && (r_kfill == 5'd0);
    assign o_key_we = in_fire && in_ch.func && !r_kfill[4];
    assign o_key_idx_w = r_kfill[3:0];
    assign o_count = r_count;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_kfill = r_kfill;
        n_outer = r_outer;
        n_hmac = r_hmac;
        n_need_pad = r_need_pad;
        n_word = r_word;
        n_count = r_count;
        n_last = r_last;
        o_cmd = '0;
        o_cmd.out_idx = r_cnt[2:0];
        o_data = r_word;
        out_ch.valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && in_ch.func) begin
                    o_data = in_ch.data_word & mask;
                    if (!r_kfill[4]) n_kfill = r_kfill + 5'd1;
                    if (in_ch.last_word) n_kfill = '0;
                end else if (in_fire) begin
                    n_count = eff_count;
                    n_last = in_ch.last_word;
                    n_word = in_ch.data_word & mask;
                    if (eff_count != 3'd4)
                        n_word = (in_ch.data_word & mask) | (PAD_WORD >> {eff_count, 3'b000});
                    n_need_pad = (eff_count == 3'd4);
                    if (i_hmac_mode && i_sts.len_zero && i_sts.fill == 4'd0) begin
                        n_state = ST_IPAD;
                        n_cnt = '0;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_IPAD: begin
                if (!i_sts.busy) begin
                    o_cmd.push = 1'b1;
                    o_cmd.src = SRC_IPAD;
                    o_cmd.key_idx = r_cnt;
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        o_cmd.len_set512 = 1'b1;
                        n_state = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (!i_sts.busy) begin
                    o_cmd.push = 1'b1;
                    o_cmd.src = SRC_DATA;
                    o_cmd.len_add = 1'b1;
                    if (!r_last) n_state = ST_IDLE;
                    else if (r_need_pad) n_state = ST_PAD;
                    else n_state = ST_ZERO;
                    n_hmac = i_hmac_mode;
                end
            end
            ST_PAD: begin
                if (!i_sts.busy) begin
                    o_cmd.push = 1'b1;
                    o_cmd.src = SRC_PAD;
                    n_state = ST_ZERO;
                end
            end
            ST_ZERO: begin
                if (!i_sts.busy) begin
                    if (i_sts.fill == 4'd14) begin
                        n_state = ST_LENHI;
                    end else begin
                        o_cmd.push = 1'b1;
                        o_cmd.src = SRC_ZERO;
                    end
                end
            end
            ST_LENHI: begin
                o_cmd.push = 1'b1;
                o_cmd.src = SRC_LENHI;
                n_state = ST_LENLO;
            end
            ST_LENLO: begin
                o_cmd.push = 1'b1;
                o_cmd.src = SRC_LENLO;
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (!i_sts.busy) begin
                    n_cnt = '0;
                    if (r_hmac && !r_outer) begin
                        o_cmd.save_inner = 1'b1;
                        o_cmd.restart = 1'b1;
                        n_outer = 1'b1;
                        n_state = ST_OPAD;
                    end else begin
                        n_outer = 1'b0;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_OPAD: begin
                if (!i_sts.busy) begin
                    o_cmd.push = 1'b1;
                    o_cmd.src = SRC_OPAD;
                    o_cmd.key_idx = r_cnt;
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        o_cmd.len_set512 = 1'b1;
                        n_cnt = '0;
                        n_state = ST_INNER;
                    end
                end
            end
            ST_INNER: begin
                if (!i_sts.busy) begin
                    o_cmd.push = 1'b1;
                    o_cmd.src = SRC_INNER;
                    o_cmd.key_idx = r_cnt;
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd7) begin
                        o_cmd.len_add256 = 1'b1;
                        n_state = ST_PAD;
                    end
                end
            end
            ST_OUT: begin
                out_ch.valid = 1'b1;
                if (out_ch.ready) begin
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd7) begin
                        o_cmd.restart = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign out_ch.digest_word = i_digest;
    assign out_ch.word_index = r_cnt[2:0];
    assign out_ch.last_result = (r_cnt == 4'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_kfill <= '0;
            r_outer <= 1'b0;
            r_hmac <= 1'b0;
            r_need_pad <= 1'b0;
            r_last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_kfill <= n_kfill;
            r_outer <= n_outer;
            r_hmac <= n_hmac;
            r_need_pad <= n_need_pad;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_count <= n_count;
    end

endmodule
